[hw/rtl/tstd_pkg.sv]
// Shared types and constants for the touch swipe/tap detector.
// Used by the controller, datapath, divider and top level; no dependencies.

package tstd_pkg;

  localparam int RAW_W   = 12;            // raw converter reading
  localparam int COORD_W = 12;            // internal screen coordinate (up to 4095)
  localparam int DIV_W   = 2 * RAW_W;     // scaled numerator magnitude
  localparam int SV_W    = DIV_W + 2;     // signed mapped value with headroom
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int NOW_W   = 32;
  localparam int DEB_W   = 16;
  localparam int THR_W   = 9;
  localparam int OX_W    = 9;             // output X field width
  localparam int OY_W    = 8;             // output Y field width
  localparam int S_DATA_W = 56;           // raw_x, raw_y, now_ms
  localparam int M_DATA_W = 40;           // gesture, tap_x, tap_y, cur_x, cur_y
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_X_MIN  = 3'd0,
    REG_RAW_X_MAX  = 3'd1,
    REG_RAW_Y_MIN  = 3'd2,
    REG_RAW_Y_MAX  = 3'd3,
    REG_FLIP       = 3'd4,
    REG_SWIPE_THR  = 3'd5,
    REG_TAP_LIMIT  = 3'd6,
    REG_DEBOUNCE   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_TAP   = 3'd1,
    GEST_LEFT  = 3'd2,
    GEST_RIGHT = 3'd3,
    GEST_UP    = 3'd4,
    GEST_DOWN  = 3'd5
  } gesture_t;

  localparam logic [RAW_W-1:0] RST_RAW_X_MIN = 12'd200;
  localparam logic [RAW_W-1:0] RST_RAW_X_MAX = 12'd3700;
  localparam logic [RAW_W-1:0] RST_RAW_Y_MIN = 12'd240;
  localparam logic [RAW_W-1:0] RST_RAW_Y_MAX = 12'd3800;
  localparam logic [THR_W-1:0] RST_SWIPE_THR = 9'd30;
  localparam logic [THR_W-1:0] RST_TAP_LIMIT = 9'd30;
  localparam logic [DEB_W-1:0] RST_DEBOUNCE  = 16'd50;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input transfer
    logic start;    // launch both divisions
    logic commit;   // update gesture state and load the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pen;      // captured pen_down
    logic busy;     // a division is running
  } dp_status_t;

  function automatic logic [COORD_W-1:0] clamp_coord(logic signed [SV_W-1:0] v,
                                                     logic [COORD_W-1:0] hi);
    logic signed [SV_W-1:0] hi_s;
    hi_s = $signed({{(SV_W-COORD_W){1'b0}}, hi});
    if (v < 0)
      return '0;
    else if (v > hi_s)
      return hi;
    else
      return v[COORD_W-1:0];
  endfunction

endpackage

[hw/rtl/tstd_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on tstd_pkg for the operand widths.

module tstd_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tstd_pkg::DIV_W-1:0] dividend,
  input  logic [tstd_pkg::RAW_W-1:0] divisor,
  output logic                      busy,
  output logic [tstd_pkg::DIV_W-1:0] quotient
);
  import tstd_pkg::*;

  logic [RAW_W-1:0] rem;
  logic [RAW_W-1:0] den;
  logic [DIV_W-1:0] dq;
  logic [CNT_W-1:0] cnt;
  logic [RAW_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, dq[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1))
        busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      // dividend shifts out the top as quotient bits shift in below
      rem <= fits ? RAW_W'(rem_sh - {1'b0, den}) : rem_sh[RAW_W-1:0];
      dq  <= {dq[DIV_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

[hw/rtl/tstd_datapath.sv]
// Datapath: config registers, calibration mapping, gesture state and output register.
// Depends on tstd_pkg and tstd_divider.

module tstd_datapath #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tstd_pkg::dp_cmd_t              cmd,
  output tstd_pkg::dp_status_t           status,
  input  logic [tstd_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  input  logic                           cfg_write,
  input  logic [tstd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tstd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [tstd_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                           m_tuser
);
  import tstd_pkg::*;

  localparam logic [COORD_W-1:0] W1 = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] H1 = COORD_W'(SCREEN_HEIGHT - 1);

  // configuration
  logic [RAW_W-1:0] x_min, x_max, y_min, y_max;
  logic             flip;
  logic [THR_W-1:0] swipe_thr, tap_lim;
  logic [DEB_W-1:0] debounce;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min     <= RST_RAW_X_MIN;
      x_max     <= RST_RAW_X_MAX;
      y_min     <= RST_RAW_Y_MIN;
      y_max     <= RST_RAW_Y_MAX;
      flip      <= 1'b0;
      swipe_thr <= RST_SWIPE_THR;
      tap_lim   <= RST_TAP_LIMIT;
      debounce  <= RST_DEBOUNCE;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_RAW_X_MIN: x_min     <= cfg_data[RAW_W-1:0];
        REG_RAW_X_MAX: x_max     <= cfg_data[RAW_W-1:0];
        REG_RAW_Y_MIN: y_min     <= cfg_data[RAW_W-1:0];
        REG_RAW_Y_MAX: y_max     <= cfg_data[RAW_W-1:0];
        REG_FLIP:      flip      <= cfg_data[0];
        REG_SWIPE_THR: swipe_thr <= cfg_data[THR_W-1:0];
        REG_TAP_LIMIT: tap_lim   <= cfg_data[THR_W-1:0];
        REG_DEBOUNCE:  debounce  <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // captured poll
  logic             pen_r;
  logic [RAW_W-1:0] rx_r, ry_r;
  logic [NOW_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pen_r <= s_tuser;
      rx_r  <= s_tdata[RAW_W-1:0];
      ry_r  <= s_tdata[2*RAW_W-1:RAW_W];
      now_r <= s_tdata[2*RAW_W+NOW_W-1:2*RAW_W];
    end
  end

  // screen X comes from raw Y, screen Y from raw X
  logic signed [RAW_W:0] num_x, span_x, num_y, span_y;
  logic [RAW_W-1:0]      nmag_x, smag_x, nmag_y, smag_y;
  logic [DIV_W-1:0]      prod_x, prod_y;

  assign num_x  = $signed({1'b0, ry_r}) - $signed({1'b0, y_min});
  assign span_x = $signed({1'b0, y_max}) - $signed({1'b0, y_min});
  assign num_y  = $signed({1'b0, rx_r}) - $signed({1'b0, x_min});
  assign span_y = $signed({1'b0, x_max}) - $signed({1'b0, x_min});

  assign nmag_x = num_x[RAW_W]  ? RAW_W'(-num_x)  : num_x[RAW_W-1:0];
  assign smag_x = span_x[RAW_W] ? RAW_W'(-span_x) : span_x[RAW_W-1:0];
  assign nmag_y = num_y[RAW_W]  ? RAW_W'(-num_y)  : num_y[RAW_W-1:0];
  assign smag_y = span_y[RAW_W] ? RAW_W'(-span_y) : span_y[RAW_W-1:0];

  assign prod_x = DIV_W'(nmag_x * W1);
  assign prod_y = DIV_W'(nmag_y * H1);

  logic neg_x, neg_y, zero_x, zero_y;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_x  <= num_x[RAW_W] ^ span_x[RAW_W];
      neg_y  <= num_y[RAW_W] ^ span_y[RAW_W];
      zero_x <= (span_x == '0);
      zero_y <= (span_y == '0);
    end
  end

  logic             busy_x, busy_y;
  logic [DIV_W-1:0] q_x, q_y;

  tstd_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (prod_x),
    .divisor  (smag_x),
    .busy     (busy_x),
    .quotient (q_x)
  );

  tstd_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (prod_y),
    .divisor  (smag_y),
    .busy     (busy_y),
    .quotient (q_y)
  );

  assign status.pen  = pen_r;
  assign status.busy = busy_x | busy_y;

  // signed, truncated-toward-zero quotients; a zero span gives a zero quotient
  logic signed [SV_W-1:0] qs_x, qs_y, xv, yv;
  logic [COORD_W-1:0]     map_x, map_y, cx, cy;

  assign qs_x = zero_x ? '0 : (neg_x ? -$signed({2'b00, q_x}) : $signed({2'b00, q_x}));
  assign qs_y = zero_y ? '0 : (neg_y ? -$signed({2'b00, q_y}) : $signed({2'b00, q_y}));
  assign xv = flip ? $signed({{(SV_W-COORD_W){1'b0}}, W1}) - qs_x : qs_x;
  assign yv = flip ? qs_y : $signed({{(SV_W-COORD_W){1'b0}}, H1}) - qs_y;
  assign map_x = clamp_coord(xv, W1);
  assign map_y = clamp_coord(yv, H1);
  assign cx = pen_r ? map_x : '0;
  assign cy = pen_r ? map_y : '0;

  // gesture state
  logic               held;
  logic [COORD_W-1:0] start_x, start_y, last_x, last_y;
  logic [NOW_W-1:0]   last_ev;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      ax, ay;
  logic [COORD_W+1:0]      ax2, ay2, ax3, ay3;
  logic                    debounced;
  gesture_t                gest_cls, gest;

  assign dx  = $signed({1'b0, last_x}) - $signed({1'b0, start_x});
  assign dy  = $signed({1'b0, last_y}) - $signed({1'b0, start_y});
  assign ax  = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ay  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  // 10a > 15b reduces to 2a > 3b
  assign ax2 = {1'b0, ax, 1'b0};
  assign ay2 = {1'b0, ay, 1'b0};
  assign ax3 = ax2 + {2'b00, ax};
  assign ay3 = ay2 + {2'b00, ay};
  assign debounced = (now_r - last_ev) >= {{(NOW_W-DEB_W){1'b0}}, debounce};

  always_comb begin
    if (ax > {{(COORD_W-THR_W){1'b0}}, swipe_thr} && ax2 > ay3)
      gest_cls = dx[COORD_W] ? GEST_LEFT : GEST_RIGHT;
    else if (ay > {{(COORD_W-THR_W){1'b0}}, swipe_thr} && ay2 > ax3)
      gest_cls = dy[COORD_W] ? GEST_UP : GEST_DOWN;
    else if (ax < {{(COORD_W-THR_W){1'b0}}, tap_lim} &&
             ay < {{(COORD_W-THR_W){1'b0}}, tap_lim})
      gest_cls = GEST_TAP;
    else
      gest_cls = GEST_NONE;
  end

  assign gest = (!pen_r && held) ? gest_cls : GEST_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      start_x <= '0;
      start_y <= '0;
      last_x  <= '0;
      last_y  <= '0;
      last_ev <= '0;
    end else if (cmd.commit) begin
      if (pen_r && !held) begin
        if (debounced) begin
          start_x <= cx;
          start_y <= cy;
          last_x  <= cx;
          last_y  <= cy;
          held    <= 1'b1;
          last_ev <= now_r;
        end
      end else if (pen_r) begin
        last_x <= cx;
        last_y <= cy;
      end else if (held) begin
        held    <= 1'b0;
        last_ev <= now_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {3'b000,
                  cy[OY_W-1:0],
                  cx[OX_W-1:0],
                  (gest == GEST_TAP) ? start_y[OY_W-1:0] : {OY_W{1'b0}},
                  (gest == GEST_TAP) ? start_x[OX_W-1:0] : {OX_W{1'b0}},
                  gest};
      m_tuser <= pen_r;
    end
  end

endmodule

[hw/rtl/tstd_ctrl.sv]
// Controller state machine: input/output handshakes and datapath sequencing.
// Depends on tstd_pkg for the command and status structs.

module tstd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output tstd_pkg::dp_cmd_t    cmd,
  input  tstd_pkg::dp_status_t status
);
  import tstd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAP  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        // a released pen needs no mapping
        if (status.pen) begin
          cmd.start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_UPD;
        end
      end
      ST_DIV: begin
        if (!status.busy)
          state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

endmodule

[hw/rtl/touch_swipe_tap_detector_core.sv]
// Top level of the touch swipe/tap detector: controller plus datapath.
// Depends on tstd_pkg, tstd_ctrl, tstd_datapath and tstd_divider.
//
// Usage:
//  - Slave stream takes one touch poll per transfer: pen_down on s_tuser,
//    raw_x, raw_y and now_ms in s_tdata.
//  - Master stream gives exactly one result per poll: pressed on m_tuser,
//    gesture, tap point and current point in m_tdata.
//  - Config channel writes calibration, flip, thresholds and debounce time by
//    index; it is always ready. The user must write it only while no poll is
//    in flight; the block itself does not enforce this.
//  - A pressed poll passes capture, launch, the two bit-serial dividers (one
//    per screen axis, run side by side) and update before its result is valid.
//    A released poll skips launch and the dividers. One poll is in flight at
//    a time; the next is taken from the cycle after the result is loaded.
//  - A result waiting in the output register does not block the next poll;
//    only the update of that next poll waits while the receiver stalls.
//  - Reset (synchronous) restores the register defaults, clears the press
//    state and the event time, and empties the output register.

module touch_swipe_tap_detector_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tstd_pkg::S_DATA_W-1:0]   s_tdata,   // raw_x[11:0] raw_y[23:12] now_ms[55:24]
  input  logic                            s_tuser,   // pen_down
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tstd_pkg::M_DATA_W-1:0]   m_tdata,   // gesture[2:0] tap_x[11:3] tap_y[19:12]
                                                     // cur_x[28:20] cur_y[36:29]
  output logic                            m_tuser,   // pressed
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tstd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tstd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tstd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tstd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tstd_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[hw/rtl/tstd_checker.sv]
// Port-level checks for the touch swipe/tap detector, bound to the top level.
// Depends on tstd_pkg for field widths and gesture codes.

module tstd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tstd_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import tstd_pkg::*;

  logic [2:0] gest;
  assign gest = m_tdata[2:0];

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one poll at a time: no transfer on the cycle right after a transfer
  a_one_poll: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("poll taken while previous poll in flight");

  // a released poll reports no current point
  a_release_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[28:20] == '0 && m_tdata[36:29] == '0)
    else $error("current point reported without pen");

  // tap point only with a tap, and gesture codes stay in range
  a_tap_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && gest != GEST_TAP |-> m_tdata[19:3] == '0 && gest <= GEST_DOWN)
    else $error("bad gesture code or stray tap point");

  // a gesture only comes with a release
  a_gest_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> gest == GEST_NONE)
    else $error("gesture reported while pressed");

endmodule

bind touch_swipe_tap_detector_core tstd_checker u_tstd_checker (.*);
